/* sv/quad_motor_mixer_desaturation_assert.svh */
// ---------------------------------------------------------------------------
// quad motor mixer assertion macros
// property shorthands used at the end of the top level
// ---------------------------------------------------------------------------
`ifndef QUAD_MOTOR_MIXER_DESATURATION_ASSERT_SVH
`define QUAD_MOTOR_MIXER_DESATURATION_ASSERT_SVH

// same-cycle implication
`define QMMD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qmmd assertion failed");

// next-cycle implication
`define QMMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qmmd assertion failed");

`endif

/* sv/qmmd_pkg.sv */
// ---------------------------------------------------------------------------
// qmmd_pkg
// constants, register indexes, sequencer states and control types
// ---------------------------------------------------------------------------
`default_nettype none

package qmmd_pkg;

	localparam int FRAC_BITS = 12;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int K_UP      = (ONE * 5 + 500) / 1000;
	localparam int K_DOWN    = (ONE + 50) / 100;
	localparam int K_TENTH   = (ONE + 5) / 10;
	localparam int K_DECAY   = (ONE * 72 + 50) / 100;

	// floor(x / 100) as (x * RECIP_K) >> RECIP_SH, exact for x < 2^20
	localparam int RECIP_SH  = 27;
	localparam int RECIP_K   = ((1 << RECIP_SH) + 99) / 100;
	localparam int PCT_MAX   = 100;

	localparam int MIX_W     = 18;
	localparam int FILT_W    = 16;
	localparam int MUL_A_W   = 29;
	localparam int MUL_B_W   = 22;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int VAL_W     = 13;
	localparam int COEF_W    = 14;
	localparam int SUM_W     = 15;

	localparam int RST_RED_LIM   = ONE / 2;
	localparam int RST_RAISE_LIM = (ONE * 2 + 5) / 10;
	localparam int RST_SQUARE    = (ONE * 277 + 500) / 1000;
	localparam int RST_LINEAR    = (ONE * 715 + 500) / 1000;
	localparam int RST_OFFSET    = (ONE * 102 + 5000) / 10000;

	typedef enum logic [2:0] {
		REG_LOWER_EN,
		REG_RAISE_EN,
		REG_RED_LIM,
		REG_RAISE_LIM,
		REG_RED_PCT,
		REG_CURVE_SQ,
		REG_CURVE_LIN,
		REG_CURVE_OFS
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MIX,
		ST_EXT,
		ST_FILT,
		ST_OSC1,
		ST_OSC2,
		ST_OSC3,
		ST_USC2,
		ST_USC3,
		ST_APPLY,
		ST_CRV1,
		ST_CRV2,
		ST_CRV3,
		ST_DONE,
		ST_DEC1,
		ST_DEC2,
		ST_DEC3
	} state_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_DECAY_OVER,
		MS_DECAY_UNDER,
		MS_PCT_OVER,
		MS_PCT_UNDER,
		MS_RECIP,
		MS_CRV_SQ,
		MS_CRV_LIN
	} mul_sel_t;

	typedef struct packed {
		logic     ready;
		logic     load_out;
		mul_sel_t mul_sel;
	} ctrl_t;

endpackage

`default_nettype wire

/* sv/quad_motor_mixer_desaturation.sv */
// ---------------------------------------------------------------------------
// quad_motor_mixer_desaturation
// X-quad motor mixer with filtered over/under-range desaturation
//
// Input beats (s_*) carry one control tick; output beats (m_*) carry the four
// motor drive values, the mean clamped thrust and the limited flag.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data,
// one register per cycle; the user must do so only while no tick is in flight,
// as the block itself does not enforce it. One shared 29x22 multiplier does
// every product: decay, percent scaling (two passes each side) and the thrust
// curve (two passes per motor), under a small sequencer. s_tready returns in
// the same cycle as m_tvalid, so a new tick is taken only once the last
// result is in the output register.
// The result sits in an output register: a stalled receiver holds m_tdata
// steady and the next tick is still taken and worked on; the sequencer waits
// only when it has a new result and the register is still full.
// Reset clears both filters, the sequencer and m_tvalid and loads the
// configuration registers with their default values.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quad_motor_mixer_desaturation_assert.svh"

module quad_motor_mixer_desaturation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// throttle_cmd, roll_corr, pitch_corr, yaw_corr, motors_off, reverse_dir,
	// bridge_hold, zero fill
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pwm_front_right, pwm_front_left, pwm_back_right, pwm_back_left,
	// mean_thrust, mix_limited, zero fill
	output logic [71:0]      m_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [13:0] cfg_data
);

	localparam int MW = qmmd_pkg::MIX_W;
	localparam int FW = qmmd_pkg::FILT_W;
	localparam int VW = qmmd_pkg::VAL_W;
	localparam int CW = qmmd_pkg::COEF_W;

	localparam logic signed [MW-1:0] C_ONE   = MW'(qmmd_pkg::ONE);
	localparam logic signed [MW-1:0] C_UP    = MW'(qmmd_pkg::K_UP);
	localparam logic signed [MW-1:0] C_DOWN  = MW'(qmmd_pkg::K_DOWN);
	localparam logic signed [MW-1:0] C_TENTH = MW'(qmmd_pkg::K_TENTH);
	localparam logic [VW-1:0]        V_ONE   = VW'(qmmd_pkg::ONE);

	// configuration
	logic          lower_en_q;
	logic          raise_en_q;
	logic [VW-1:0] red_lim_q;
	logic [VW-1:0] raise_lim_q;
	logic [6:0]    red_pct_q;
	logic [CW-1:0] curve_sq_q;
	logic [CW-1:0] curve_lin_q;
	logic [CW-1:0] curve_ofs_q;

	// captured tick
	logic [VW-1:0] thr_q;
	logic [CW-1:0] roll_q;
	logic [CW-1:0] pitch_q;
	logic [CW-1:0] yaw_q;
	logic          off_q;
	logic          rev_q;
	logic          wait_q;

	// working state
	qmmd_pkg::state_t state_q, state_n;
	qmmd_pkg::ctrl_t  ctrl;
	logic signed [MW-1:0] mix_q [4];
	logic signed [MW-1:0] hi_q;
	logic signed [MW-1:0] lo_q;
	logic signed [FW-1:0] of_q;
	logic signed [FW-1:0] uf_q;
	logic [VW-1:0]        over_amt_q;
	logic [VW-1:0]        under_mag_q;
	logic [1:0]           idx_q;
	logic [VW-1:0]        pwm_w_q [4];
	logic [qmmd_pkg::SUM_W-1:0] sum_q;
	logic                 lim_w_q;

	// output register
	logic [VW-1:0] out_pwm_q [4];
	logic [VW-1:0] out_mean_q;
	logic          out_lim_q;
	logic          m_tvalid_q;

	// shared multiplier
	logic signed [qmmd_pkg::MUL_A_W-1:0] mul_a;
	logic signed [qmmd_pkg::MUL_B_W-1:0] mul_b;
	logic signed [qmmd_pkg::PROD_W-1:0]  prod_q;

	// combinational helpers
	logic signed [MW-1:0] mix_n [4];
	logic signed [MW-1:0] hi_n;
	logic signed [MW-1:0] lo_n;
	logic signed [FW-1:0] of_n;
	logic signed [FW-1:0] uf_n;
	logic [6:0]           pct_sat;
	logic [VW-1:0]        m_over;
	logic [VW-1:0]        m_under;
	logic [FW:0]          uf_neg;
	logic [VW-1:0]        x_cur;
	logic [VW-1:0]        crv_val;
	logic signed [qmmd_pkg::PROD_W-1:0] crv_acc;
	logic signed [qmmd_pkg::PROD_W-1:0] dec_sum;
	logic [qmmd_pkg::SUM_W-1:0] mean_sum;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_en_q  <= 1'b1;
			raise_en_q  <= 1'b0;
			red_lim_q   <= VW'(qmmd_pkg::RST_RED_LIM);
			raise_lim_q <= VW'(qmmd_pkg::RST_RAISE_LIM);
			red_pct_q   <= 7'(qmmd_pkg::PCT_MAX);
			curve_sq_q  <= CW'(qmmd_pkg::RST_SQUARE);
			curve_lin_q <= CW'(qmmd_pkg::RST_LINEAR);
			curve_ofs_q <= CW'(qmmd_pkg::RST_OFFSET);
		end else if (cfg_wr_en) begin
			case (qmmd_pkg::reg_idx_t'(cfg_index))
				qmmd_pkg::REG_LOWER_EN:  lower_en_q  <= cfg_data[0];
				qmmd_pkg::REG_RAISE_EN:  raise_en_q  <= cfg_data[0];
				qmmd_pkg::REG_RED_LIM:   red_lim_q   <= cfg_data[VW-1:0];
				qmmd_pkg::REG_RAISE_LIM: raise_lim_q <= cfg_data[VW-1:0];
				qmmd_pkg::REG_RED_PCT:   red_pct_q   <= cfg_data[6:0];
				qmmd_pkg::REG_CURVE_SQ:  curve_sq_q  <= cfg_data;
				qmmd_pkg::REG_CURVE_LIN: curve_lin_q <= cfg_data;
				qmmd_pkg::REG_CURVE_OFS: curve_ofs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_n = state_q;
		case (state_q)
			qmmd_pkg::ST_IDLE:  if (s_tvalid) state_n = qmmd_pkg::ST_MIX;
			qmmd_pkg::ST_MIX:   state_n = off_q ? qmmd_pkg::ST_DEC1 : qmmd_pkg::ST_EXT;
			qmmd_pkg::ST_EXT:   state_n = qmmd_pkg::ST_FILT;
			qmmd_pkg::ST_FILT:  state_n = qmmd_pkg::ST_OSC1;
			qmmd_pkg::ST_OSC1:  state_n = qmmd_pkg::ST_OSC2;
			qmmd_pkg::ST_OSC2:  state_n = qmmd_pkg::ST_OSC3;
			qmmd_pkg::ST_OSC3:  state_n = qmmd_pkg::ST_USC2;
			qmmd_pkg::ST_USC2:  state_n = qmmd_pkg::ST_USC3;
			qmmd_pkg::ST_USC3:  state_n = qmmd_pkg::ST_APPLY;
			qmmd_pkg::ST_APPLY: state_n = qmmd_pkg::ST_CRV1;
			qmmd_pkg::ST_CRV1:  state_n = qmmd_pkg::ST_CRV2;
			qmmd_pkg::ST_CRV2:  state_n = qmmd_pkg::ST_CRV3;
			qmmd_pkg::ST_CRV3:  state_n = (idx_q == 2'd3) ? qmmd_pkg::ST_DONE : qmmd_pkg::ST_CRV1;
			qmmd_pkg::ST_DONE:  if (!m_tvalid_q || m_tready) state_n = qmmd_pkg::ST_IDLE;
			qmmd_pkg::ST_DEC1:  state_n = qmmd_pkg::ST_DEC2;
			qmmd_pkg::ST_DEC2:  state_n = qmmd_pkg::ST_DEC3;
			qmmd_pkg::ST_DEC3:  state_n = qmmd_pkg::ST_DONE;
			default:            state_n = qmmd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{ready: 1'b0, load_out: 1'b0, mul_sel: qmmd_pkg::MS_NONE};
		case (state_q)
			qmmd_pkg::ST_IDLE: ctrl.ready   = 1'b1;
			qmmd_pkg::ST_OSC1: ctrl.mul_sel = qmmd_pkg::MS_PCT_OVER;
			qmmd_pkg::ST_OSC2: ctrl.mul_sel = qmmd_pkg::MS_RECIP;
			qmmd_pkg::ST_OSC3: ctrl.mul_sel = qmmd_pkg::MS_PCT_UNDER;
			qmmd_pkg::ST_USC2: ctrl.mul_sel = qmmd_pkg::MS_RECIP;
			qmmd_pkg::ST_CRV1: ctrl.mul_sel = qmmd_pkg::MS_CRV_SQ;
			qmmd_pkg::ST_CRV2: ctrl.mul_sel = qmmd_pkg::MS_CRV_LIN;
			qmmd_pkg::ST_DEC1: ctrl.mul_sel = qmmd_pkg::MS_DECAY_OVER;
			qmmd_pkg::ST_DEC2: ctrl.mul_sel = qmmd_pkg::MS_DECAY_UNDER;
			qmmd_pkg::ST_DONE: ctrl.load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qmmd_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign s_tready = ctrl.ready;

	// ---------------- mixing and filter arithmetic ----------------
	always_comb begin
		logic [VW-1:0]        t_c;
		logic signed [MW-1:0] t_e;
		logic signed [MW-1:0] r_e;
		logic signed [MW-1:0] p_e;
		logic signed [MW-1:0] y_e;
		t_c = (thr_q > V_ONE) ? V_ONE : thr_q;
		t_e = {{(MW-VW){1'b0}}, t_c};
		r_e = {{(MW-CW){roll_q[CW-1]}}, roll_q};
		p_e = {{(MW-CW){pitch_q[CW-1]}}, pitch_q};
		y_e = {{(MW-CW){yaw_q[CW-1]}}, yaw_q};
		if (rev_q) begin
			r_e = -r_e;
			p_e = -p_e;
			y_e = -y_e;
		end
		mix_n[0] = t_e - r_e - p_e + y_e;
		mix_n[1] = t_e + r_e - p_e - y_e;
		mix_n[2] = t_e - r_e + p_e - y_e;
		mix_n[3] = t_e + r_e + p_e + y_e;
	end

	always_comb begin
		hi_n = '0;
		lo_n = '0;
		for (int i = 0; i < 4; i++) begin
			if (mix_q[i] > hi_n) hi_n = mix_q[i];
			if (mix_q[i] < lo_n) lo_n = mix_q[i];
		end
	end

	always_comb begin
		logic signed [MW-1:0] lim_e;
		logic signed [MW-1:0] rl_e;
		logic signed [MW-1:0] ov;
		logic signed [MW-1:0] un;
		logic signed [MW-1:0] of_e;
		logic signed [MW-1:0] uf_e;
		logic signed [MW-1:0] of_t;
		logic signed [MW-1:0] uf_t;
		lim_e = {{(MW-VW){1'b0}}, red_lim_q};
		rl_e  = -{{(MW-VW){1'b0}}, raise_lim_q};
		of_e  = {{(MW-FW){of_q[FW-1]}}, of_q};
		uf_e  = {{(MW-FW){uf_q[FW-1]}}, uf_q};
		ov = hi_q - C_ONE;
		if (ov > lim_e) ov = lim_e;
		of_t = (ov > of_e) ? of_e + C_UP : of_e - C_DOWN;
		if (of_t > lim_e) of_t = lim_e;
		if (of_t < -C_TENTH) of_t = -C_TENTH;
		of_n = of_t[FW-1:0];
		un = lo_q;
		if (un < rl_e) un = rl_e;
		uf_t = (un < uf_e) ? uf_e - C_UP : uf_e + C_DOWN;
		if (uf_t < -lim_e) uf_t = -lim_e;
		if (uf_t > C_TENTH) uf_t = C_TENTH;
		uf_n = raise_en_q ? uf_t[FW-1:0] : uf_q;
	end

	assign pct_sat = (red_pct_q > 7'(qmmd_pkg::PCT_MAX)) ? 7'(qmmd_pkg::PCT_MAX) : red_pct_q;
	assign m_over  = (lower_en_q && of_q > 0) ? of_q[VW-1:0] : '0;
	assign uf_neg  = -{uf_q[FW-1], uf_q};
	assign m_under = (raise_en_q && uf_q < 0) ? uf_neg[VW-1:0] : '0;

	assign x_cur = mix_q[idx_q][MW-1] ? '0 :
		((mix_q[idx_q] > C_ONE) ? V_ONE : mix_q[idx_q][VW-1:0]);

	// ---------------- shared multiplier ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			qmmd_pkg::MS_DECAY_OVER: begin
				mul_a = {{(qmmd_pkg::MUL_A_W-FW){of_q[FW-1]}}, of_q};
				mul_b = qmmd_pkg::MUL_B_W'(qmmd_pkg::K_DECAY);
			end
			qmmd_pkg::MS_DECAY_UNDER: begin
				mul_a = {{(qmmd_pkg::MUL_A_W-FW){uf_q[FW-1]}}, uf_q};
				mul_b = qmmd_pkg::MUL_B_W'(qmmd_pkg::K_DECAY);
			end
			qmmd_pkg::MS_PCT_OVER: begin
				mul_a = {{(qmmd_pkg::MUL_A_W-VW){1'b0}}, m_over};
				mul_b = {{(qmmd_pkg::MUL_B_W-7){1'b0}}, pct_sat};
			end
			qmmd_pkg::MS_PCT_UNDER: begin
				mul_a = {{(qmmd_pkg::MUL_A_W-VW){1'b0}}, m_under};
				mul_b = {{(qmmd_pkg::MUL_B_W-7){1'b0}}, pct_sat};
			end
			qmmd_pkg::MS_RECIP: begin
				mul_a = {{(qmmd_pkg::MUL_A_W-21){1'b0}}, prod_q[20:0] + 21'd50};
				mul_b = qmmd_pkg::MUL_B_W'(qmmd_pkg::RECIP_K);
			end
			qmmd_pkg::MS_CRV_SQ: begin
				mul_a = {{(qmmd_pkg::MUL_A_W-CW){curve_sq_q[CW-1]}}, curve_sq_q};
				mul_b = {{(qmmd_pkg::MUL_B_W-VW){1'b0}}, x_cur};
			end
			qmmd_pkg::MS_CRV_LIN: begin
				mul_a = prod_q[qmmd_pkg::MUL_A_W-1:0]
					+ {{(qmmd_pkg::MUL_A_W-CW-qmmd_pkg::FRAC_BITS){curve_lin_q[CW-1]}},
					curve_lin_q, {qmmd_pkg::FRAC_BITS{1'b0}}};
				mul_b = {{(qmmd_pkg::MUL_B_W-VW){1'b0}}, x_cur};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// curve rounding and saturation
	always_comb begin
		logic signed [26:0] r;
		crv_acc = prod_q
			+ {{(qmmd_pkg::PROD_W-CW-2*qmmd_pkg::FRAC_BITS){curve_ofs_q[CW-1]}},
			curve_ofs_q, {(2*qmmd_pkg::FRAC_BITS){1'b0}}}
			+ (qmmd_pkg::PROD_W'(1) << (2*qmmd_pkg::FRAC_BITS - 1));
		r = crv_acc[2*qmmd_pkg::FRAC_BITS +: 27];
		if (r[26]) begin
			crv_val = '0;
		end else if (r > 27'sd4096) begin
			crv_val = V_ONE;
		end else begin
			crv_val = r[VW-1:0];
		end
	end

	assign dec_sum  = prod_q + (qmmd_pkg::PROD_W'(1) << (qmmd_pkg::FRAC_BITS - 1));
	assign mean_sum = sum_q + qmmd_pkg::SUM_W'(2);

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_tvalid && ctrl.ready) begin
			thr_q   <= s_tdata[12:0];
			roll_q  <= s_tdata[26:13];
			pitch_q <= s_tdata[40:27];
			yaw_q   <= s_tdata[54:41];
			off_q   <= s_tdata[55];
			rev_q   <= s_tdata[56];
			wait_q  <= s_tdata[57];
		end
		case (state_q)
			qmmd_pkg::ST_MIX: begin
				for (int i = 0; i < 4; i++) begin
					mix_q[i]   <= mix_n[i];
					pwm_w_q[i] <= '0;
				end
				sum_q   <= '0;
				lim_w_q <= 1'b0;
				idx_q   <= '0;
			end
			qmmd_pkg::ST_EXT: begin
				hi_q <= hi_n;
				lo_q <= lo_n;
			end
			qmmd_pkg::ST_OSC3: over_amt_q  <= prod_q[qmmd_pkg::RECIP_SH +: VW];
			qmmd_pkg::ST_USC3: under_mag_q <= prod_q[qmmd_pkg::RECIP_SH +: VW];
			qmmd_pkg::ST_APPLY: begin
				lim_w_q <= (over_amt_q != '0) || (under_mag_q != '0);
				for (int i = 0; i < 4; i++) begin
					mix_q[i] <= mix_q[i] - {{(MW-VW){1'b0}}, over_amt_q}
						+ {{(MW-VW){1'b0}}, under_mag_q};
				end
			end
			qmmd_pkg::ST_CRV3: begin
				pwm_w_q[idx_q] <= wait_q ? '0 : crv_val;
				sum_q          <= sum_q + {{(qmmd_pkg::SUM_W-VW){1'b0}}, x_cur};
				idx_q          <= idx_q + 2'd1;
			end
			default: ;
		endcase
		if (ctrl.load_out) begin
			out_pwm_q  <= pwm_w_q;
			out_mean_q <= mean_sum[2 +: VW];
			out_lim_q  <= lim_w_q;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_q <= '0;
			uf_q <= '0;
		end else begin
			case (state_q)
				qmmd_pkg::ST_FILT: begin
					of_q <= of_n;
					uf_q <= uf_n;
				end
				qmmd_pkg::ST_DEC2: of_q <= dec_sum[qmmd_pkg::FRAC_BITS +: FW];
				qmmd_pkg::ST_DEC3: uf_q <= dec_sum[qmmd_pkg::FRAC_BITS +: FW];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_lim_q, out_mean_q,
		out_pwm_q[3], out_pwm_q[2], out_pwm_q[1], out_pwm_q[0]};

	// ---------------- assertions ----------------
	`QMMD_ASSERT_NXT(a_accept_starts_mix, clk, arst_n, s_tvalid && s_tready, state_q == qmmd_pkg::ST_MIX)
	`QMMD_ASSERT_IMP(a_over_filter_floor, clk, arst_n, 1'b1, int'(of_q) >= -qmmd_pkg::K_TENTH)
	`QMMD_ASSERT_IMP(a_off_result_zero, clk, arst_n, state_q == qmmd_pkg::ST_DONE && off_q, !lim_w_q && sum_q == '0)
	`QMMD_ASSERT_IMP(a_limited_matches, clk, arst_n, state_q == qmmd_pkg::ST_DONE && !off_q, lim_w_q == (over_amt_q != '0 || under_mag_q != '0))

endmodule

`default_nettype wire
